// File: src/ufe_pkg.sv
`timescale 1ns / 1ps

package ufe_pkg;

  localparam int unsigned TAG_W  = 10;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_FIND  = 2'd1,
    REQ_MERGE = 2'd2,
    REQ_SIZE  = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SIZE,
    S_UP,
    S_CMP,
    S_FOUND,
    S_SZA,
    S_LINK,
    S_RESP
  } ufe_state_e;

  // One access cycle on the parent table.
  typedef struct packed {
    logic             we;
    logic [TAG_W-1:0] waddr;
    logic [TAG_W-1:0] wdata;
    logic             re;
    logic [TAG_W-1:0] raddr;
  } par_req_t;

  // One access cycle on the size table.
  typedef struct packed {
    logic              we;
    logic [TAG_W-1:0]  waddr;
    logic [SIZE_W-1:0] wdata;
    logic              re;
    logic [TAG_W-1:0]  raddr;
  } siz_req_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    stat_e             status;
  } ufe_res_t;

endpackage

// File: src/ufe_ram.sv
`timescale 1ns / 1ps

module ufe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ufe_ctrl.sv
`timescale 1ns / 1ps

module ufe_ctrl
  import ufe_pkg::*;
#(
  parameter int unsigned MAX_ELEMS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_e              in_req_i,
  input  logic [TAG_W-1:0]  in_a_i,
  input  logic [TAG_W-1:0]  in_b_i,
  output par_req_t          par_o,
  input  logic [TAG_W-1:0]  par_rdata_i,
  output siz_req_t          siz_o,
  input  logic [SIZE_W-1:0] siz_rdata_i,
  output ufe_res_t          res_o,
  input  logic              res_ready_i
);

  localparam int unsigned DEPTH = (MAX_ELEMS > (1 << TAG_W)) ? (1 << TAG_W) : MAX_ELEMS;
  localparam int unsigned CW    = $clog2(MAX_ELEMS + 1);
  localparam int unsigned XW    = (CW > TAG_W) ? CW : TAG_W;

  ufe_state_e        state_q, state_d;
  req_e              req_q, req_d;
  logic [TAG_W-1:0]  a_q, a_d, b_q, b_d;
  logic [TAG_W-1:0]  cur_q, cur_d, start_q, start_d;
  logic [TAG_W-1:0]  root_q, root_d, ra_q, ra_d;
  logic              phase_q, phase_d;
  logic [SIZE_W-1:0] sa_q, sa_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [SIZE_W-1:0] size_q, size_d;
  stat_e             status_q, status_d;
  logic [CW-1:0]     count_q, count_d;

  logic a_ok, b_ok;

  assign a_ok = XW'(a_q) < XW'(count_q);
  assign b_ok = XW'(b_q) < XW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    a_q      <= a_d;
    b_q      <= b_d;
    cur_q    <= cur_d;
    start_q  <= start_d;
    root_q   <= root_d;
    ra_q     <= ra_d;
    phase_q  <= phase_d;
    sa_q     <= sa_d;
    tag_q    <= tag_d;
    size_q   <= size_d;
    status_q <= status_d;
  end

  always_comb begin
    logic [SIZE_W-1:0] sb;
    logic              swap;
    state_d    = state_q;
    req_d      = req_q;
    a_d        = a_q;
    b_d        = b_q;
    cur_d      = cur_q;
    start_d    = start_q;
    root_d     = root_q;
    ra_d       = ra_q;
    phase_d    = phase_q;
    sa_d       = sa_q;
    tag_d      = tag_q;
    size_d     = size_q;
    status_d   = status_q;
    count_d    = count_q;
    in_ready_o = 1'b0;
    par_o      = '0;
    siz_o      = '0;
    res_o      = '0;
    sb         = siz_rdata_i;
    swap       = sa_q < sb;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_req_i;
          a_d     = in_a_i;
          b_d     = in_b_i;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        tag_d    = '0;
        size_d   = '0;
        status_d = STAT_OK;
        state_d  = S_RESP;
        unique case (req_q)
          REQ_ADD: begin
            if (count_q >= CW'(MAX_ELEMS)) begin
              status_d = STAT_FULL;
            end else begin
              // Tags past the tag range can never be named; skip their entries.
              if (XW'(count_q) < XW'(DEPTH)) begin
                par_o.we    = 1'b1;
                par_o.waddr = TAG_W'(count_q);
                par_o.wdata = TAG_W'(count_q);
                siz_o.we    = 1'b1;
                siz_o.waddr = TAG_W'(count_q);
                siz_o.wdata = SIZE_W'(1);
              end
              tag_d   = TAG_W'(count_q);
              count_d = count_q + CW'(1);
            end
          end
          REQ_SIZE: begin
            if (!a_ok) begin
              status_d = STAT_INVALID;
            end else begin
              siz_o.re    = 1'b1;
              siz_o.raddr = a_q;
              state_d     = S_SIZE;
            end
          end
          REQ_FIND, REQ_MERGE: begin
            if (!a_ok || (req_q == REQ_MERGE && !b_ok)) begin
              status_d = STAT_INVALID;
            end else begin
              cur_d       = a_q;
              start_d     = a_q;
              phase_d     = 1'b0;
              par_o.re    = 1'b1;
              par_o.raddr = a_q;
              state_d     = S_UP;
            end
          end
          default: status_d = STAT_INVALID;
        endcase
      end

      S_SIZE: begin
        size_d  = siz_rdata_i;
        state_d = S_RESP;
      end

      // Climb toward the root, one parent read per cycle.
      S_UP: begin
        if (par_rdata_i == cur_q) begin
          root_d = cur_q;
          if (start_q == cur_q) begin
            state_d = S_FOUND;
          end else begin
            cur_d       = start_q;
            par_o.re    = 1'b1;
            par_o.raddr = start_q;
            state_d     = S_CMP;
          end
        end else begin
          cur_d       = par_rdata_i;
          par_o.re    = 1'b1;
          par_o.raddr = par_rdata_i;
        end
      end

      // Walk the path again, pointing each node at the root.
      S_CMP: begin
        par_o.we    = 1'b1;
        par_o.waddr = cur_q;
        par_o.wdata = root_q;
        if (par_rdata_i == root_q) begin
          state_d = S_FOUND;
        end else begin
          cur_d       = par_rdata_i;
          par_o.re    = 1'b1;
          par_o.raddr = par_rdata_i;
        end
      end

      S_FOUND: begin
        if (req_q == REQ_FIND) begin
          tag_d   = root_q;
          state_d = S_RESP;
        end else if (!phase_q) begin
          ra_d        = root_q;
          phase_d     = 1'b1;
          cur_d       = b_q;
          start_d     = b_q;
          par_o.re    = 1'b1;
          par_o.raddr = b_q;
          state_d     = S_UP;
        end else if (root_q == ra_q) begin
          tag_d   = ra_q;
          state_d = S_RESP;
        end else begin
          siz_o.re    = 1'b1;
          siz_o.raddr = ra_q;
          state_d     = S_SZA;
        end
      end

      S_SZA: begin
        sa_d        = siz_rdata_i;
        siz_o.re    = 1'b1;
        siz_o.raddr = root_q;
        state_d     = S_LINK;
      end

      // Link the smaller root under the larger; ties keep the first root.
      S_LINK: begin
        par_o.we    = 1'b1;
        par_o.waddr = swap ? ra_q : root_q;
        par_o.wdata = swap ? root_q : ra_q;
        siz_o.we    = 1'b1;
        siz_o.waddr = swap ? root_q : ra_q;
        siz_o.wdata = sa_q + sb;
        tag_d       = swap ? root_q : ra_q;
        state_d     = S_RESP;
      end

      S_RESP: begin
        res_o.valid  = 1'b1;
        res_o.tag    = tag_q;
        res_o.size   = size_q;
        res_o.status = status_q;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMS))
    else $error("element count past capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("element count moved by more than one");

  a_full_only_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == STAT_FULL) |-> (count_q == CW'(MAX_ELEMS)))
    else $error("full status with room left");

  a_par_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (par_o.we && par_o.re) |-> (par_o.waddr != par_o.raddr))
    else $error("parent table read and write hit one entry");

endmodule

// File: src/union_find_engine.sv
// Union-find engine with union by size and full path compression. Each input
// word carries a request kind in tuser (add, find, merge, size) and two element
// tags in tdata; each request returns exactly one output word with the tag, the
// size count and a status (ok, invalid tag, table full) in tuser. Parent links
// and size counts live in two single-port-pair RAMs with registered reads, so the
// cost of a request is set by the number of dependent parent-table reads. The
// next word is taken in the cycle after its result enters the output register.
// Add, an invalid tag and a full table go straight to the response; a size
// query first reads the size table; a find climbs from the element to its root
// with one climb read per link and then walks the path again with one re-point
// write per link; a merge finds both roots and, when they differ, reads both
// sizes and links the two roots.
// There is no clearing pass after reset: the element count starts at zero and
// only entries that an add has written are ever read. One request is worked at
// a time; the next word is taken while a finished result still waits in the
// output register.
`timescale 1ns / 1ps

module union_find_engine
  import ufe_pkg::*;
#(
  parameter int unsigned MAX_ELEMS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] elem_a, [19:10] elem_b, [23:20] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] result_tag, [20:10] set_size, [23:21] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  // Only tags below the tag range can ever be looked up, so cap the tables there.
  localparam int unsigned DEPTH = (MAX_ELEMS > (1 << TAG_W)) ? (1 << TAG_W) : MAX_ELEMS;
  localparam int unsigned AW    = $clog2(DEPTH);

  par_req_t          par;
  siz_req_t          siz;
  logic [TAG_W-1:0]  par_rdata;
  logic [SIZE_W-1:0] siz_rdata;
  ufe_res_t          res;
  logic              out_free;

  logic              m_valid_q, m_valid_d;
  logic [23:0]       m_data_q, m_data_d;
  logic [1:0]        m_user_q, m_user_d;

  ufe_ctrl #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (req_e'(s_axis_tuser)),
    .in_a_i     (s_axis_tdata[9:0]),
    .in_b_i     (s_axis_tdata[19:10]),
    .par_o      (par),
    .par_rdata_i(par_rdata),
    .siz_o      (siz),
    .siz_rdata_i(siz_rdata),
    .res_o      (res),
    .res_ready_i(out_free)
  );

  // Parent links: one entry per element, a root points at itself.
  ufe_ram #(
    .WIDTH(TAG_W),
    .DEPTH(DEPTH)
  ) u_par_ram (
    .clk_i  (clk_i),
    .we_i   (par.we),
    .waddr_i(par.waddr[AW-1:0]),
    .wdata_i(par.wdata),
    .re_i   (par.re),
    .raddr_i(par.raddr[AW-1:0]),
    .rdata_o(par_rdata)
  );

  // Size counts: exact for roots, stale for anything linked below a root.
  ufe_ram #(
    .WIDTH(SIZE_W),
    .DEPTH(DEPTH)
  ) u_siz_ram (
    .clk_i  (clk_i),
    .we_i   (siz.we),
    .waddr_i(siz.waddr[AW-1:0]),
    .wdata_i(siz.wdata),
    .re_i   (siz.re),
    .raddr_i(siz.raddr[AW-1:0]),
    .rdata_o(siz_rdata)
  );

  // Output register: take a result whenever the slot is empty or draining.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (out_free) begin
      m_valid_d = res.valid;
      if (res.valid) begin
        m_data_d = {3'b000, res.size, res.tag};
        m_user_d = res.status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: tb/sv/union_find_engine_tb.sv
`timescale 1ns / 1ps

module union_find_engine_tb;
  import ufe_pkg::*;

  localparam int unsigned ELEM_MAX    = 1024;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 80;
  localparam int unsigned IDLE_PCT    = 26;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    stat_e             status;
  } uf_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [9:0] elem_a, [19:10] elem_b, [23:20] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [9:0] result_tag, [20:10] set_size, [23:21] zero
  logic [1:0]  m_axis_tuser;        // [1:0] status

  // Shadow copy of the disjoint-set state.
  logic [TAG_W-1:0]  parent_link [ELEM_MAX];
  logic [SIZE_W-1:0] size_count  [ELEM_MAX];
  int unsigned       elem_count = 0;

  uf_word_t    pending_res[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle = 1'b0;

  union_find_engine #(.MAX_ELEMS(ELEM_MAX)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[union_find_engine] ERROR");
      $finish;
    end
  end

  // Stall the result side at random, except during the quiet stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic bit tag_valid(input logic [TAG_W-1:0] t);
    return int'(t) < elem_count;
  endfunction

  // Walk to the root, then point every node on the path straight at it.
  function automatic logic [TAG_W-1:0] root_of(input logic [TAG_W-1:0] t);
    logic [TAG_W-1:0] r;
    logic [TAG_W-1:0] nxt;
    r = t;
    while (parent_link[r] != r) r = parent_link[r];
    while (t != r) begin
      nxt = parent_link[t];
      parent_link[t] = r;
      t = nxt;
    end
    return r;
  endfunction

  function automatic uf_word_t apply_request(input req_e kind, input logic [TAG_W-1:0] a,
                                             input logic [TAG_W-1:0] b);
    uf_word_t         res;
    logic [TAG_W-1:0] ra;
    logic [TAG_W-1:0] rb;
    logic [TAG_W-1:0] tmp;
    res = '{tag: '0, size: '0, status: STAT_OK};
    unique case (kind)
      REQ_ADD: begin
        if (elem_count >= ELEM_MAX) begin
          res.status = STAT_FULL;
        end else begin
          parent_link[elem_count] = elem_count[TAG_W-1:0];
          size_count[elem_count]  = SIZE_W'(1);
          res.tag = elem_count[TAG_W-1:0];
          elem_count++;
        end
      end
      REQ_FIND: begin
        if (!tag_valid(a)) res.status = STAT_INVALID;
        else res.tag = root_of(a);
      end
      REQ_MERGE: begin
        if (!tag_valid(a) || !tag_valid(b)) begin
          res.status = STAT_INVALID;
        end else begin
          ra = root_of(a);
          rb = root_of(b);
          if (ra != rb) begin
            // Smaller set goes under the larger; a tie keeps the root of elem_a.
            if (size_count[ra] < size_count[rb]) begin
              tmp = ra;
              ra  = rb;
              rb  = tmp;
            end
            parent_link[rb] = ra;
            size_count[ra]  = size_count[ra] + size_count[rb];
          end
          res.tag = ra;
        end
      end
      default: begin
        if (!tag_valid(a)) res.status = STAT_INVALID;
        else res.size = size_count[a];
      end
    endcase
    return res;
  endfunction

  // Mostly a live tag, sometimes an edge value or any 10-bit tag.
  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    if (r < 16 || elem_count == 0) return TAG_W'($urandom_range(0, ELEM_MAX - 1));
    return TAG_W'($urandom_range(0, elem_count - 1));
  endfunction

  // Offer one word, hold it until taken, then record what it must return.
  task automatic send_req(input req_e kind, input logic [TAG_W-1:0] a,
                          input logic [TAG_W-1:0] b);
    uf_word_t exp_word;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, b, a};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_word    = apply_request(kind, a, b);
    pending_res = {pending_res, exp_word};
  endtask

  task automatic send_random(input int unsigned add_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < add_pct) begin
      send_req(REQ_ADD, pick_tag(), pick_tag());
    end else begin
      r = $urandom_range(0, 2);
      if (r == 0) send_req(REQ_FIND, pick_tag(), pick_tag());
      else if (r == 1) send_req(REQ_MERGE, pick_tag(), pick_tag());
      else send_req(REQ_SIZE, pick_tag(), pick_tag());
    end
  endtask

  // Compare each output word with the oldest expectation.
  always @(posedge clk_i) begin
    uf_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected word tdata=%h tuser=%h", $time, m_axis_tdata, m_axis_tuser);
        mismatch_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (m_axis_tdata[9:0] !== want.tag) begin
          $display("%0t: result_tag expected %0d actual %0d", $time, want.tag,
                   m_axis_tdata[9:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[20:10] !== want.size) begin
          $display("%0t: set_size expected %0d actual %0d", $time, want.size,
                   m_axis_tdata[20:10]);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  // Every request on an empty table names an element that does not exist.
  task automatic test_empty_table();
    send_req(REQ_FIND, '0, '0);
    send_req(REQ_MERGE, '1, '1);
    send_req(REQ_SIZE, '0, '1);
  endtask

  // Build a three-level tree, then exercise ties, the smaller-first merge,
  // merging within one set, stale counts and out-of-range tags.
  task automatic test_directed();
    for (int i = 0; i < 8; i++) send_req(REQ_ADD, '0, '0);
    send_req(REQ_MERGE, 10'd0, 10'd1);
    send_req(REQ_MERGE, 10'd2, 10'd3);
    send_req(REQ_MERGE, 10'd0, 10'd2);
    send_req(REQ_MERGE, 10'd4, 10'd5);
    send_req(REQ_MERGE, 10'd6, 10'd7);
    send_req(REQ_MERGE, 10'd4, 10'd6);
    send_req(REQ_MERGE, 10'd0, 10'd4);
    send_req(REQ_FIND, 10'd7, '0);
    send_req(REQ_SIZE, 10'd4, '0);
    send_req(REQ_SIZE, 10'd0, '0);
    send_req(REQ_ADD, '0, '0);
    send_req(REQ_MERGE, 10'd8, 10'd0);
    send_req(REQ_MERGE, 10'd3, 10'd7);
    send_req(REQ_FIND, 10'd9, '0);
    send_req(REQ_MERGE, 10'd1, '1);
    send_req(REQ_MERGE, '1, 10'd1);
    send_req(REQ_SIZE, '1, '0);
  endtask

  // Grow the table to capacity under a random mix; run one stretch with
  // no idling on either side.
  task automatic test_random_grow();
    int unsigned n;
    n = 0;
    while (elem_count < ELEM_MAX) begin
      no_idle = (n >= 400 && n < 650);
      send_random(75);
      n++;
    end
    no_idle = 1'b0;
  endtask

  // Full table: adds are refused, every tag is live.
  task automatic test_full_table();
    send_req(REQ_ADD, '1, '1);
    send_req(REQ_FIND, '1, '0);
    send_req(REQ_MERGE, '1, '0);
    send_req(REQ_SIZE, '1, '0);
    for (int i = 0; i < 80; i++) send_random(25);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_directed();
    test_random_grow();
    test_full_table();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[union_find_engine] OK");
    end else begin
      $display("[union_find_engine] ERROR");
    end
    $finish;
  end

endmodule
